[src/pcrs_pkg.sv]
// Package: shared types and constants for the pool card request scheduler.
`timescale 1ns / 1ps
package pcrs_pkg;
    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_UPD = 2'd1;
    localparam logic [1:0] MODE_SCH = 2'd2;

    localparam logic [1:0] CFG_NPOOL = 2'd0;
    localparam logic [1:0] CFG_LAT   = 2'd1;
    localparam logic [1:0] CFG_NCARD = 2'd2;
    localparam logic [1:0] CFG_MAP   = 2'd3;

    typedef struct packed {
        logic [15:0] rid;
        logic [15:0] uid;
        logic        lat;
        logic [4:0]  need;
    } t_entry;

    typedef struct packed {
        logic        start;
        logic [15:0] uid;
        logic        lat;
        logic [3:0]  npools;
    } t_pick_req;

    typedef struct packed {
        logic       done;
        logic [3:0] pool;
    } t_pick_rsp;
endpackage

[src/pcrs_pool_pick.sv]
// Pool selection unit: matched-pool scan and iterative user id modulo count.
`timescale 1ns / 1ps
module pcrs_pool_pick #(
    parameter int NUM_POOLS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_lat_mask,
    input  pcrs_pkg::t_pick_req i_req,
    output pcrs_pkg::t_pick_rsp o_rsp
);
    import pcrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_SEL  = 3'b100
    } t_state;

    t_state      r_state;
    logic [15:0] r_rem;
    logic [4:0]  r_bit;
    logic [4:0]  r_n;
    logic [15:0] r_match;
    logic [15:0] r_uid;
    logic [3:0]  r_pool;
    logic        r_done;

    logic [15:0] w_match;
    logic [4:0]  w_cnt;
    logic [16:0] w_sh;
    logic [3:0]  w_sel;

    always_comb begin
        logic [15:0] m;
        logic [4:0]  c;
        m = '0;
        for (int p = 0; p < 16; p++) begin
            if (p < NUM_POOLS && 5'(p) < {1'b0, i_req.npools}) begin
                if (((p < 8) ? i_lat_mask[p % 8] : 1'b0) == i_req.lat) begin
                    m[p] = 1'b1;
                end
            end
        end
        if (m == '0) begin
            for (int p = 0; p < 16; p++) begin
                if (p < NUM_POOLS && 5'(p) < {1'b0, i_req.npools}) begin
                    m[p] = 1'b1;
                end
            end
        end
        c = '0;
        for (int p = 0; p < 16; p++) begin
            c = c + 5'(m[p]);
        end
        w_match = m;
        w_cnt   = c;
    end

    assign w_sh = {r_rem, r_uid[15]};

    always_comb begin
        logic [4:0] k;
        logic [3:0] s;
        k = '0;
        s = '0;
        for (int p = 0; p < 16; p++) begin
            if (r_match[p]) begin
                if (k == r_rem[4:0]) begin
                    s = 4'(p);
                end
                k = k + 5'd1;
            end
        end
        w_sel = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_match <= w_match;
                        r_n     <= w_cnt;
                        r_uid   <= i_req.uid;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_sh >= {12'd0, r_n}) begin
                        r_rem <= 16'(w_sh - {12'd0, r_n});
                    end else begin
                        r_rem <= w_sh[15:0];
                    end
                    r_uid <= {r_uid[14:0], 1'b0};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd15) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_pool  <= w_sel;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.pool = r_pool;
endmodule

[src/pcrs_card_scan.sv]
// Card gathering unit: walks the cards one per cycle, preferred then others.
`timescale 1ns / 1ps
module pcrs_card_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [3:0]  i_pool,
    input  logic [15:0] i_uid,
    input  logic [4:0]  i_need,
    input  logic [4:0]  i_ncards,
    input  logic [31:0] i_now,
    input  logic [47:0] i_map,
    input  logic [15:0] i_busy,
    input  logic [15:0][31:0] i_avail,
    input  logic [15:0] i_rvalid,
    input  logic [15:0][15:0] i_ruser,
    output logic        o_done,
    output logic        o_ok,
    output logic [15:0] o_mask
);
    import pcrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PICK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [4:0]  r_c;
    logic [15:0] r_pref;
    logic [15:0] r_rest;
    logic [4:0]  r_total;
    logic [4:0]  r_got;
    logic [15:0] r_mask;
    logic        r_pass;
    logic        r_done;
    logic        r_ok;

    logic [3:0]  w_ci;
    logic        w_free;

    assign w_ci   = r_c[3:0];
    assign w_free = ({1'b0, i_map[3*w_ci +: 3]} == i_pool) && !i_busy[w_ci]
                    && (i_now >= i_avail[w_ci]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_c     <= '0;
                        r_pref  <= '0;
                        r_rest  <= '0;
                        r_total <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_c >= i_ncards) begin
                        r_c     <= '0;
                        r_got   <= '0;
                        r_mask  <= '0;
                        r_pass  <= 1'b0;
                        r_state <= (r_total < i_need) ? S_FIN : S_PICK;
                    end else begin
                        if (w_free) begin
                            if (i_rvalid[w_ci] && i_ruser[w_ci] == i_uid) begin
                                r_pref[w_ci] <= 1'b1;
                            end else begin
                                r_rest[w_ci] <= 1'b1;
                            end
                            r_total <= r_total + 5'd1;
                        end
                        r_c <= r_c + 5'd1;
                    end
                end
                S_PICK: begin
                    if (r_got >= i_need) begin
                        r_state <= S_FIN;
                    end else if (r_c >= 5'd16) begin
                        r_c    <= '0;
                        r_pass <= 1'b1;
                        if (r_pass) begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        if (r_pass ? r_rest[w_ci] : r_pref[w_ci]) begin
                            r_mask[w_ci] <= 1'b1;
                            r_got        <= r_got + 5'd1;
                        end
                        r_c <= r_c + 5'd1;
                    end
                end
                S_FIN: begin
                    r_ok    <= (r_total >= i_need);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ok   = r_ok;
    assign o_mask = r_mask;
endmodule

[src/pool_card_request_scheduler.sv]
// Top level: request queue, card table and schedule sequencer.
// channel | dir | signals
// in      | in  | i_valid / o_ready, i_mode .. i_now_time
// out     | out | o_valid / i_ready, o_scheduled .. o_dropped
// cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data
// Enqueue, card update, unused mode: the accept edge enters S_OUT, which raises o_valid.
// Schedule: each request tried is loaded (S_LOAD), given a pool (S_POOL) and has
// its cards walked (S_CARD); a miss steps on to the next entry (S_NEXT), a hit
// ends the walk and shifts later entries down (S_SHIFT). S_OUT raises o_valid.
// Synchronous active-low reset clears queue length, card table and control registers.
// Ready is low while an item is in work or its result waits.
`timescale 1ns / 1ps
module pool_card_request_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_POOLS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_request_id,
    input  logic [15:0] i_user_id,
    input  logic        i_latency_flag,
    input  logic [4:0]  i_cards_needed,
    input  logic [3:0]  i_card_index,
    input  logic        i_card_busy,
    input  logic [31:0] i_card_free_time,
    input  logic        i_resident_valid,
    input  logic [15:0] i_resident_user,
    input  logic [31:0] i_now_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_scheduled,
    output logic [15:0] o_plan_request_id,
    output logic [15:0] o_card_mask,
    output logic        o_queue_empty,
    output logic        o_dropped,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import pcrs_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_POOL  = 7'b0000100,
        S_CARD  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state      r_state;
    logic [3:0]  r_npool;
    logic [7:0]  r_lat;
    logic [4:0]  r_ncard;
    logic [47:0] r_map;
    t_entry      r_q [QUEUE_DEPTH];
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_i;
    logic [15:0] r_busy;
    logic [15:0][31:0] r_avail;
    logic [15:0] r_rv;
    logic [15:0][15:0] r_ru;
    t_entry      r_e;
    logic [31:0] r_now;
    logic [3:0]  r_pool;
    logic        r_sched;
    logic [15:0] r_prid;
    logic [15:0] r_mask;
    logic        r_drop;
    logic        r_ovalid;
    logic        r_pstart;
    logic        r_cstart;

    t_pick_req   w_preq;
    t_pick_rsp   w_prsp;
    logic        w_cdone;
    logic        w_cok;
    logic [15:0] w_cmask;
    logic [3:0]  w_np;
    logic [4:0]  w_nc;

    assign w_np = ({28'd0, r_npool} > 32'(NUM_POOLS)) ? 4'(NUM_POOLS) : r_npool;
    assign w_nc = (r_ncard > 5'd16) ? 5'd16 : r_ncard;

    assign w_preq.start  = r_pstart;
    assign w_preq.uid    = r_e.uid;
    assign w_preq.lat    = r_e.lat;
    assign w_preq.npools = w_np;

    pcrs_pool_pick #(.NUM_POOLS(NUM_POOLS)) u_pick (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lat_mask(r_lat),
        .i_req(w_preq), .o_rsp(w_prsp)
    );

    pcrs_card_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cstart), .i_pool(r_pool),
        .i_uid(r_e.uid), .i_need(r_e.need), .i_ncards(w_nc), .i_now(r_now),
        .i_map(r_map), .i_busy(r_busy), .i_avail(r_avail), .i_rvalid(r_rv),
        .i_ruser(r_ru), .o_done(w_cdone), .o_ok(w_cok), .o_mask(w_cmask)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready && i_mode == MODE_ENQ
            && r_len < LW'(QUEUE_DEPTH)) begin
            r_q[r_len[QW-1:0]] <= '{i_request_id, i_user_id, i_latency_flag,
                                    i_cards_needed};
        end else if (r_state == S_SHIFT && r_i + LW'(1) < r_len) begin
            r_q[r_i[QW-1:0]] <= r_q[QW'(r_i + LW'(1))];
        end
        if (r_state == S_LOAD) begin
            r_e <= r_q[r_i[QW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_npool  <= 4'd1;
            r_lat    <= '0;
            r_ncard  <= '0;
            r_map    <= '0;
            r_len    <= '0;
            r_busy   <= '0;
            r_avail  <= '0;
            r_rv     <= '0;
            r_ru     <= '0;
            r_ovalid <= 1'b0;
            r_pstart <= 1'b0;
            r_cstart <= 1'b0;
        end else begin
            r_pstart <= 1'b0;
            r_cstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NPOOL: r_npool <= i_cfg_data[3:0];
                    CFG_LAT:   r_lat   <= i_cfg_data[7:0];
                    CFG_NCARD: r_ncard <= i_cfg_data[4:0];
                    CFG_MAP:   r_map   <= i_cfg_data;
                    default:   r_map   <= r_map;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_sched <= 1'b0;
                        r_prid  <= '0;
                        r_mask  <= '0;
                        r_drop  <= 1'b0;
                        r_now   <= i_now_time;
                        r_i     <= '0;
                        r_state <= S_OUT;
                        case (i_mode)
                            MODE_ENQ: begin
                                if (r_len < LW'(QUEUE_DEPTH)) begin
                                    r_len <= r_len + LW'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                            MODE_UPD: begin
                                r_busy[i_card_index]  <= i_card_busy;
                                r_avail[i_card_index] <= i_card_free_time;
                                r_rv[i_card_index]    <= i_resident_valid;
                                r_ru[i_card_index]    <= i_resident_user;
                            end
                            MODE_SCH: begin
                                if (w_np != 4'd0 && r_len != '0) begin
                                    r_state <= S_LOAD;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_pstart <= 1'b1;
                    r_state  <= S_POOL;
                end
                S_POOL: begin
                    if (w_prsp.done) begin
                        r_pool   <= w_prsp.pool;
                        r_cstart <= 1'b1;
                        r_state  <= S_CARD;
                    end
                end
                S_CARD: begin
                    if (w_cdone) begin
                        if (w_cok) begin
                            r_sched <= 1'b1;
                            r_prid  <= r_e.rid;
                            r_mask  <= w_cmask;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_i + LW'(1) < r_len) begin
                        r_i <= r_i + LW'(1);
                    end else begin
                        r_len   <= r_len - LW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_NEXT: begin
                    if (r_i + LW'(1) < r_len) begin
                        r_i     <= r_i + LW'(1);
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_scheduled       = r_sched;
    assign o_plan_request_id = r_prid;
    assign o_card_mask       = r_mask;
    assign o_queue_empty     = (r_len == '0);
    assign o_dropped         = r_drop;
endmodule

[src/pcrs_checker.sv]
// Port-level assertions for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module pcrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_scheduled,
    input logic [15:0] o_plan_request_id,
    input logic [15:0] o_card_mask,
    input logic        o_dropped
);
    a_no_ready_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_card_mask))
        else $error("result beat changed while stalled");
    a_unsched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_scheduled |-> o_card_mask == 16'd0 && o_plan_request_id == 16'd0)
        else $error("plan fields set without plan");
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_dropped && o_scheduled)) else $error("drop and plan together");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready right after accept");
endmodule

bind pool_card_request_scheduler pcrs_checker u_pcrs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_scheduled(o_scheduled),
    .o_plan_request_id(o_plan_request_id), .o_card_mask(o_card_mask),
    .o_dropped(o_dropped)
);
